// File: rtl/rltm_pkg.sv
// Package of constants and codes shared by the redo log transaction manager.
`timescale 1ns / 1ps
`default_nettype none
package rltm_pkg;
    localparam int LOG_ENTRIES_DEFAULT          = 16;
    localparam int BLOCKS_PER_OPERATION_DEFAULT = 4;

    localparam logic [31:0] LOG_START_RESET    = 32'd2;
    localparam logic [15:0] LOG_CAPACITY_RESET = 16'd17;

    localparam logic [0:0] CFG_LOG_START    = 1'b0;
    localparam logic [0:0] CFG_LOG_CAPACITY = 1'b1;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] KIND_RESPONSE = 2'd0;
    localparam logic [1:0] KIND_COPY     = 2'd1;
    localparam logic [1:0] KIND_COUNT    = 2'd2;
    localparam logic [1:0] KIND_ENTRY    = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WAIT      = 3'd1;
    localparam logic [2:0] ST_TOO_BIG   = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;
endpackage
`default_nettype wire

// File: rtl/rltm_entry_table.sv
// Entry table memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rltm_entry_table
    import rltm_pkg::*;
#(
    parameter int LOG_ENTRIES = LOG_ENTRIES_DEFAULT,
    localparam int AW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [31:0]   rd_data
);
    logic [31:0] mem [LOG_ENTRIES];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// File: rtl/redo_log_transaction_manager_unit.sv
// Top level of the redo log transaction manager with group commit.
//
// Channel | Direction | Handshake              | Payload
// in      | in        | in_valid / in_ready    | opcode, block_number
// out     | out       | out_valid / out_ready  | kind, status, source_block, target_block,
//         |           |                        | entry_index, entry_value, last
// cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request is handled at a time. A log write scans the table entries in turn: each
// entry is read from the table memory in one state and compared with the block in the
// next. A commit run reads the table once for each copy or entry result it emits.
// Reset is asynchronous and clears the counts, the configuration and the output valid
// flag; the table needs no clearing. A stalled output holds the sequencer in place.
`timescale 1ns / 1ps
`default_nettype none
module redo_log_transaction_manager_unit
    import rltm_pkg::*;
#(
    parameter int LOG_ENTRIES          = LOG_ENTRIES_DEFAULT,
    parameter int BLOCKS_PER_OPERATION = BLOCKS_PER_OPERATION_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] block_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [2:0]       status,
    output logic [31:0]      source_block,
    output logic [31:0]      target_block,
    output logic [3:0]       entry_index,
    output logic [31:0]      entry_value,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int AW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
    localparam int CW = $clog2(LOG_ENTRIES + 1);
    localparam int OW = $clog2(LOG_ENTRIES + 2);
    localparam int NW = CW + OW + 6;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_RUN_RD, S_RUN_EMIT, S_HDR, S_RESP
    } state_t;

    typedef enum logic [2:0] {
        PH_LOG, PH_CNT, PH_ENT, PH_HOME, PH_CLR
    } phase_t;

    state_t        state_reg, state_next;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [OW-1:0] open_reg, open_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0]   blk_reg, blk_next;
    logic [2:0]    resp_reg, resp_next;
    logic [31:0]   log_start_reg;
    logic [15:0]   log_capacity_reg;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [2:0]    status_reg, status_next;
    logic [31:0]   src_reg, src_next;
    logic [31:0]   dst_reg, dst_next;
    logic [3:0]    eidx_reg, eidx_next;
    logic [31:0]   eval_reg, eval_next;
    logic          last_reg, last_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [31:0]   rd_data;
    logic          out_free;
    logic          idx_last;
    logic [NW-1:0] need;
    logic          log_full;
    logic [31:0]   log_slot;

    rltm_entry_table #(
        .LOG_ENTRIES(LOG_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (blk_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign idx_last = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign need     = NW'(count_reg) + (NW'(open_reg) + NW'(1)) * NW'(BLOCKS_PER_OPERATION);
    assign log_full = (count_reg >= CW'(LOG_ENTRIES))
                   || ((17'(count_reg) + 17'd1) >= 17'(log_capacity_reg));
    assign log_slot = log_start_reg + 32'(idx_reg) + 32'd1;
    assign wr_addr  = count_reg[AW-1:0];
    assign rd_en    = (state_reg == S_SCAN_RD) || (state_reg == S_RUN_RD);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        open_next      = open_reg;
        idx_next       = idx_reg;
        blk_next       = blk_reg;
        resp_next      = resp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        status_next    = status_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        eidx_next      = eidx_reg;
        eval_next      = eval_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    blk_next   = block_number;
                    resp_next  = ST_OK;
                    idx_next   = '0;
                    state_next = S_RESP;
                    case (opcode)
                        OP_BEGIN:
                        begin
                            if (need > NW'(LOG_ENTRIES))
                            begin
                                resp_next = ST_WAIT;
                            end
                            else
                            begin
                                open_next = open_reg + OW'(1);
                            end
                        end
                        OP_END:
                        begin
                            if (open_reg == '0)
                            begin
                                resp_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                open_next = open_reg - OW'(1);
                                if (open_reg == OW'(1) && count_reg != '0)
                                begin
                                    phase_next = PH_LOG;
                                    state_next = S_RUN_RD;
                                end
                            end
                        end
                        OP_WRITE:
                        begin
                            if (log_full)
                            begin
                                resp_next = ST_TOO_BIG;
                            end
                            else if (open_reg == '0)
                            begin
                                resp_next = ST_OUTSIDE;
                            end
                            else if (count_reg != '0)
                            begin
                                state_next = S_SCAN_RD;
                            end
                            else
                            begin
                                state_next = S_SCAN_CMP;
                            end
                        end
                        default:
                        begin
                            resp_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (count_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_RESP;
                end
                else if (rd_data == blk_reg)
                begin
                    state_next = S_RESP;
                end
                else if (idx_last)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_RUN_RD:
            begin
                state_next = S_RUN_EMIT;
            end
            S_RUN_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    last_next      = 1'b0;
                    eidx_next      = '0;
                    eval_next      = '0;
                    src_next       = '0;
                    dst_next       = '0;
                    case (phase_reg)
                        PH_LOG:
                        begin
                            kind_next = KIND_COPY;
                            src_next  = rd_data;
                            dst_next  = log_slot;
                        end
                        PH_ENT:
                        begin
                            kind_next = KIND_ENTRY;
                            dst_next  = log_start_reg;
                            eidx_next = 4'(idx_reg);
                            eval_next = rd_data;
                        end
                        default:
                        begin
                            kind_next = KIND_COPY;
                            src_next  = log_slot;
                            dst_next  = rd_data;
                        end
                    endcase
                    if (!idx_last)
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RUN_RD;
                    end
                    else
                    begin
                        idx_next = '0;
                        case (phase_reg)
                            PH_LOG:
                            begin
                                phase_next = PH_CNT;
                                state_next = S_HDR;
                            end
                            PH_ENT:
                            begin
                                phase_next = PH_HOME;
                                state_next = S_RUN_RD;
                            end
                            default:
                            begin
                                phase_next = PH_CLR;
                                state_next = S_HDR;
                            end
                        endcase
                    end
                end
            end
            S_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_COUNT;
                    status_next    = ST_OK;
                    src_next       = '0;
                    dst_next       = log_start_reg;
                    eidx_next      = '0;
                    last_next      = 1'b0;
                    idx_next       = '0;
                    if (phase_reg == PH_CNT)
                    begin
                        eval_next  = 32'(count_reg);
                        phase_next = PH_ENT;
                        state_next = S_RUN_RD;
                    end
                    else
                    begin
                        eval_next  = '0;
                        count_next = '0;
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_RESPONSE;
                    status_next    = resp_reg;
                    src_next       = '0;
                    dst_next       = '0;
                    eidx_next      = '0;
                    eval_next      = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_LOG;
            count_reg        <= '0;
            open_reg         <= '0;
            idx_reg          <= '0;
            resp_reg         <= ST_OK;
            out_valid_reg    <= 1'b0;
            log_start_reg    <= LOG_START_RESET;
            log_capacity_reg <= LOG_CAPACITY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            open_reg      <= open_next;
            idx_reg       <= idx_next;
            resp_reg      <= resp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_LOG_START)
                begin
                    log_start_reg <= cfg_data;
                end
                else if (cfg_index == CFG_LOG_CAPACITY)
                begin
                    log_capacity_reg <= cfg_data[15:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg    <= blk_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        eidx_reg   <= eidx_next;
        eval_reg   <= eval_next;
        last_reg   <= last_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign source_block = src_reg;
    assign target_block = dst_reg;
    assign entry_index  = eidx_reg;
    assign entry_value  = eval_reg;
    assign last         = last_reg;
endmodule
`default_nettype wire

// File: rtl/rltm_checker.sv
// Port-level checker for the redo log transaction manager and its bind.
`timescale 1ns / 1ps
`default_nettype none
module rltm_checker
    import rltm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  kind,
    input wire logic [2:0]  status,
    input wire logic [31:0] source_block,
    input wire logic [31:0] target_block,
    input wire logic        last
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
        else $error("Stalled result changed.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Request taken while another was in progress.");

    a_last_is_response: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_RESPONSE) == last))
        else $error("Final flag does not mark the response.");

    a_status_only_on_response: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_RESPONSE |-> status == ST_OK)
        else $error("Status set on a non-response result.");

    a_response_blocks_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RESPONSE |-> source_block == '0 && target_block == '0)
        else $error("Response carries block numbers.");
endmodule

bind redo_log_transaction_manager_unit rltm_checker u_rltm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .status       (status),
    .source_block (source_block),
    .target_block (target_block),
    .last         (last)
);
`default_nettype wire
